// ----- hw/rtl/ssb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled sprite blit package
// Shared types, codes and default sizes of the sprite blit block.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int unsigned SCREEN_W_DEF    = 1024;
  localparam int unsigned SCREEN_H_DEF    = 768;
  localparam int unsigned TEX_ENTRIES_DEF = 4096;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 16;

  localparam int unsigned QW = 7;
  localparam int unsigned PW = 19;

  localparam logic [31:0] MAGENTA = 32'h00FF_00FF;

  typedef enum logic [1:0] {
    OP_TEXEL = 2'd0,
    OP_DEPTH = 2'd1,
    OP_DRAW  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_DEST_X       = 3'd0,
    CFG_DEST_Y       = 3'd1,
    CFG_DRAW_WIDTH   = 3'd2,
    CFG_DRAW_HEIGHT  = 3'd3,
    CFG_TEX_WIDTH    = 3'd4,
    CFG_TEX_HEIGHT   = 3'd5,
    CFG_SPRITE_DEPTH = 3'd6,
    CFG_KEY_COLOR    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [12:0] dest_x;
    logic [12:0] dest_y;
    logic [11:0] draw_width;
    logic [11:0] draw_height;
    logic [6:0]  tex_width;
    logic [6:0]  tex_height;
    logic [23:0] sprite_depth;
    logic [31:0] key_color;
  } cfg_t;

  typedef struct packed {
    op_e           op;
    logic          ok;
    logic [11:0]   x;
    logic [11:0]   y;
    logic [11:0]   idx;
    logic [31:0]   val;
    logic [PW-1:0] nx;
    logic [PW-1:0] ny;
  } item_t;

  typedef struct packed {
    logic        we;
    logic [19:0] addr;
    logic [31:0] color;
  } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ssb_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite blit queue
// Small first-in first-out buffer with a power-of-two depth.
// ----------------------------------------------------------------------------
module ssb_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              empty_o
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [W-1:0] mem_q [DEPTH];
  logic [AW:0]  wr_q, wr_d, rd_q, rd_d;

  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
  assign data_o  = mem_q[rd_q[AW-1:0]];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_i && !full_o) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i && !empty_o) begin
      rd_d = rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q[AW-1:0]] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ssb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite blit front end
// Accepts items, classifies them and forms the scaled texel products.
// ----------------------------------------------------------------------------
module ssb_front #(
  parameter int unsigned SCREEN_W    = ssb_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H    = ssb_pkg::SCREEN_H_DEF,
  parameter int unsigned TEX_ENTRIES = ssb_pkg::TEX_ENTRIES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ssb_pkg::cfg_t cfg_i,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [1:0]    opcode_i,
  input  wire logic [11:0]   load_index_i,
  input  wire logic [31:0]   load_value_i,
  input  wire logic [11:0]   offset_x_i,
  input  wire logic [11:0]   offset_y_i,
  output logic               item_valid_o,
  output ssb_pkg::item_t     item_o,
  input  wire logic          mid_full_i
);
  logic                 valid_q, valid_d;
  ssb_pkg::item_t       item_q, item_d;
  logic                 take;
  logic signed [13:0]   xs, ys;
  logic                 in_box, on_scr;
  ssb_pkg::op_e         op;

  assign full_o       = valid_q && mid_full_i;
  assign take         = push_i && !full_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;
  assign op           = ssb_pkg::op_e'(opcode_i);

  always_comb begin
    xs = $signed({cfg_i.dest_x[12], cfg_i.dest_x}) + $signed({2'b00, offset_x_i});
    ys = $signed({cfg_i.dest_y[12], cfg_i.dest_y}) + $signed({2'b00, offset_y_i});
    in_box = (offset_x_i < cfg_i.draw_width) && (offset_y_i < cfg_i.draw_height);
    on_scr = (xs > 14'sd0) && (ys > 14'sd0) &&
             (xs < $signed(14'(SCREEN_W))) && (ys < $signed(14'(SCREEN_H)));
    item_d.op  = op;
    item_d.x   = xs[11:0];
    item_d.y   = ys[11:0];
    item_d.idx = load_index_i;
    item_d.val = load_value_i;
    item_d.nx  = {7'b0, offset_x_i} * {12'b0, cfg_i.tex_width};
    item_d.ny  = {7'b0, offset_y_i} * {12'b0, cfg_i.tex_height};
    case (op)
      ssb_pkg::OP_TEXEL: item_d.ok = 17'(load_index_i) < 17'(TEX_ENTRIES);
      ssb_pkg::OP_DEPTH: item_d.ok = 13'(load_index_i) < 13'(SCREEN_W);
      ssb_pkg::OP_DRAW:  item_d.ok = in_box && on_scr;
      default:           item_d.ok = 1'b0;
    endcase
    valid_d = valid_q;
    if (!valid_q || !mid_full_i) begin
      valid_d = take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ssb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite blit back end
// Divides for the texel coordinate, updates and reads the stores, and
// applies the color key and depth tests.
// ----------------------------------------------------------------------------
module ssb_back #(
  parameter int unsigned SCREEN_W    = ssb_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H    = ssb_pkg::SCREEN_H_DEF,
  parameter int unsigned TEX_ENTRIES = ssb_pkg::TEX_ENTRIES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ssb_pkg::cfg_t  cfg_i,
  input  wire logic           item_valid_i,
  input  wire ssb_pkg::item_t item_i,
  output logic                res_valid_o,
  output ssb_pkg::res_t       res_o
);
  localparam int unsigned TAW = $clog2(TEX_ENTRIES);
  localparam int unsigned DAW = $clog2(SCREEN_W);
  localparam int unsigned QW  = ssb_pkg::QW;
  localparam int unsigned PW  = ssb_pkg::PW;
  localparam int unsigned YW  = $clog2(SCREEN_H) + 1;

  typedef struct packed {
    ssb_pkg::op_e  op;
    logic          ok;
    logic [11:0]   x;
    logic [11:0]   y;
    logic [11:0]   idx;
    logic [31:0]   val;
    logic [PW-1:0] rx;
    logic [PW-1:0] ry;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
  } div_t;

  typedef struct packed {
    ssb_pkg::op_e op;
    logic         ok;
    logic [11:0]  x;
    logic [11:0]  y;
    logic [11:0]  idx;
    logic [31:0]  val;
    logic [13:0]  taddr;
  } addr_t;

  typedef struct packed {
    ssb_pkg::op_e op;
    logic         ok;
    logic [11:0]  x;
    logic [11:0]  y;
  } mem_t;

  logic  d_v_q [QW+1];
  div_t  d_q   [QW+1];
  div_t  d_d   [QW+1];
  logic  a_v_q, m_v_q, r_v_q;
  addr_t a_q, a_d;
  mem_t  m_q;
  ssb_pkg::res_t r_q, r_d;

  logic [31:0] tmem [TEX_ENTRIES];
  logic [23:0] dmem [SCREEN_W];
  logic [31:0] tex_rd_q;
  logic [23:0] dep_rd_q;
  logic [16:0] ta_ext, ti_ext;
  logic [13:0] prod;
  logic [23:0] lin;

  always_comb begin
    d_d[0].op  = item_i.op;
    d_d[0].ok  = item_i.ok;
    d_d[0].x   = item_i.x;
    d_d[0].y   = item_i.y;
    d_d[0].idx = item_i.idx;
    d_d[0].val = item_i.val;
    d_d[0].rx  = item_i.nx;
    d_d[0].ry  = item_i.ny;
    d_d[0].qx  = '0;
    d_d[0].qy  = '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [PW-1:0] tx, ty;
    always_comb begin
      tx = {7'b0, cfg_i.draw_width} << (QW - 1 - k);
      ty = {7'b0, cfg_i.draw_height} << (QW - 1 - k);
      d_d[k+1] = d_q[k];
      if (d_q[k].rx >= tx) begin
        d_d[k+1].rx = d_q[k].rx - tx;
        d_d[k+1].qx[QW-1-k] = 1'b1;
      end
      if (d_q[k].ry >= ty) begin
        d_d[k+1].ry = d_q[k].ry - ty;
        d_d[k+1].qy[QW-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QW; i++) begin
        d_v_q[i] <= 1'b0;
      end
      a_v_q <= 1'b0;
      m_v_q <= 1'b0;
      r_v_q <= 1'b0;
    end else begin
      d_v_q[0] <= item_valid_i;
      for (int i = 1; i <= QW; i++) begin
        d_v_q[i] <= d_v_q[i-1];
      end
      a_v_q <= d_v_q[QW];
      m_v_q <= a_v_q;
      r_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= QW; i++) begin
      d_q[i] <= d_d[i];
    end
  end

  always_comb begin
    prod      = {7'b0, d_q[QW].qy} * {7'b0, cfg_i.tex_width};
    a_d.op    = d_q[QW].op;
    a_d.x     = d_q[QW].x;
    a_d.y     = d_q[QW].y;
    a_d.idx   = d_q[QW].idx;
    a_d.val   = d_q[QW].val;
    a_d.taddr = prod + 14'(d_q[QW].qx);
    a_d.ok    = d_q[QW].ok;
    if (d_q[QW].op == ssb_pkg::OP_DRAW) begin
      a_d.ok = d_q[QW].ok && (17'(a_d.taddr) < 17'(TEX_ENTRIES));
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
  end

  assign ta_ext = 17'(a_q.taddr);
  assign ti_ext = 17'(a_q.idx);

  always_ff @(posedge clk_i) begin
    if (a_v_q && a_q.ok && a_q.op == ssb_pkg::OP_TEXEL) begin
      tmem[ti_ext[TAW-1:0]] <= a_q.val;
    end
    if (a_v_q && a_q.ok && a_q.op == ssb_pkg::OP_DEPTH) begin
      dmem[a_q.idx[DAW-1:0]] <= a_q.val[23:0];
    end
    tex_rd_q <= tmem[ta_ext[TAW-1:0]];
    dep_rd_q <= dmem[a_q.x[DAW-1:0]];
    m_q.op   <= a_q.op;
    m_q.ok   <= a_q.ok;
    m_q.x    <= a_q.x;
    m_q.y    <= a_q.y;
  end

  always_comb begin
    lin = 24'(m_q.y[YW-2:0]) * 24'(SCREEN_W) + 24'(m_q.x);
    r_d.we = (m_q.op == ssb_pkg::OP_DRAW) && m_q.ok &&
             (tex_rd_q != cfg_i.key_color) && (cfg_i.sprite_depth < dep_rd_q);
    r_d.addr  = r_d.we ? lin[19:0] : '0;
    r_d.color = r_d.we ? tex_rd_q : '0;
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  assign res_valid_o = r_v_q;
  assign res_o       = r_q;

endmodule
`default_nettype wire

// ----- hw/rtl/scaled_sprite_blit_depth_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled sprite blit with depth test
// Top level: configuration registers, front end, queues and back end.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while full is low and returns
// exactly one result per transaction, in order. Texel and column depth loads
// travel the same pipeline as draws, so a draw always sees every load taken
// before it. The texel coordinate comes from two seven-stage restoring
// dividers that produce one quotient bit per stage; a credit of sixteen
// results in flight, set by the result queue depth, keeps the back end from
// ever stalling. Configuration registers may only be written while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module scaled_sprite_blit_depth_test #(
  parameter int unsigned SCREEN_W    = ssb_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H    = ssb_pkg::SCREEN_H_DEF,
  parameter int unsigned TEX_ENTRIES = ssb_pkg::TEX_ENTRIES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [11:0] load_index_i,
  input  wire logic [31:0] load_value_i,
  input  wire logic [11:0] offset_x_i,
  input  wire logic [11:0] offset_y_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             write_enable_o,
  output logic [19:0]      screen_address_o,
  output logic [31:0]      pixel_color_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam int unsigned OD = ssb_pkg::OUT_DEPTH;
  localparam int unsigned CW = $clog2(OD + 1);

  ssb_pkg::cfg_t  cfg_q;
  ssb_pkg::item_t front_item, mid_item;
  logic           front_valid, mid_full, mid_empty, back_take;
  logic           res_valid;
  ssb_pkg::res_t  res, out_res;
  logic [CW-1:0]  cnt_q, cnt_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x       <= '0;
      cfg_q.dest_y       <= '0;
      cfg_q.draw_width   <= '0;
      cfg_q.draw_height  <= '0;
      cfg_q.tex_width    <= 7'd64;
      cfg_q.tex_height   <= 7'd64;
      cfg_q.sprite_depth <= '0;
      cfg_q.key_color    <= ssb_pkg::MAGENTA;
    end else if (cfg_valid_i) begin
      case (ssb_pkg::cfg_idx_e'(cfg_index_i))
        ssb_pkg::CFG_DEST_X:       cfg_q.dest_x       <= cfg_data_i[12:0];
        ssb_pkg::CFG_DEST_Y:       cfg_q.dest_y       <= cfg_data_i[12:0];
        ssb_pkg::CFG_DRAW_WIDTH:   cfg_q.draw_width   <= cfg_data_i[11:0];
        ssb_pkg::CFG_DRAW_HEIGHT:  cfg_q.draw_height  <= cfg_data_i[11:0];
        ssb_pkg::CFG_TEX_WIDTH:    cfg_q.tex_width    <= cfg_data_i[6:0];
        ssb_pkg::CFG_TEX_HEIGHT:   cfg_q.tex_height   <= cfg_data_i[6:0];
        ssb_pkg::CFG_SPRITE_DEPTH: cfg_q.sprite_depth <= cfg_data_i[23:0];
        ssb_pkg::CFG_KEY_COLOR:    cfg_q.key_color    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ssb_front #(
    .SCREEN_W    (SCREEN_W),
    .SCREEN_H    (SCREEN_H),
    .TEX_ENTRIES (TEX_ENTRIES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .full_o       (full),
    .opcode_i     (opcode_i),
    .load_index_i (load_index_i),
    .load_value_i (load_value_i),
    .offset_x_i   (offset_x_i),
    .offset_y_i   (offset_y_i),
    .item_valid_o (front_valid),
    .item_o       (front_item),
    .mid_full_i   (mid_full)
  );

  ssb_fifo #(
    .W     ($bits(ssb_pkg::item_t)),
    .DEPTH (ssb_pkg::MID_DEPTH)
  ) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .full_o  (mid_full),
    .pop_i   (back_take),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  assign back_take = !mid_empty && (cnt_q < CW'(OD));

  always_comb begin
    cnt_d = cnt_q;
    if (back_take && !(pop && !empty)) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!back_take && pop && !empty) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  ssb_back #(
    .SCREEN_W    (SCREEN_W),
    .SCREEN_H    (SCREEN_H),
    .TEX_ENTRIES (TEX_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (back_take),
    .item_i       (mid_item),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ssb_fifo #(
    .W     ($bits(ssb_pkg::res_t)),
    .DEPTH (OD)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign write_enable_o   = out_res.we;
  assign screen_address_o = out_res.addr;
  assign pixel_color_o    = out_res.color;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Scaled sprite blit testbench
// Loads texels and column depths, then streams draw transactions under
// several register settings. Random gaps on both queue sides and one long
// hold-off on the result side are applied. An in-order scoreboard predicts
// each result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import ssb_pkg::*;

  localparam int unsigned SCR_W     = SCREEN_W_DEF;
  localparam int unsigned SCR_H     = SCREEN_H_DEF;
  localparam int unsigned TEX_N     = TEX_ENTRIES_DEF;
  localparam int unsigned MAX_CYCLE = 400000;
  localparam int unsigned DRAIN     = 40;

  class blit_scoreboard;
    logic [12:0] dest_x, dest_y;
    logic [11:0] draw_w, draw_h;
    logic [6:0]  tex_w, tex_h;
    logic [23:0] sprite_z;
    logic [31:0] key;
    logic [31:0] texels [TEX_N];
    bit          tex_set [TEX_N];
    logic [23:0] col_z [SCR_W];
    bit          col_set [SCR_W];
    res_t        pending [$];
    int          errors;

    function new();
      dest_x = '0; dest_y = '0; draw_w = '0; draw_h = '0;
      tex_w = 7'd64; tex_h = 7'd64; sprite_z = '0; key = MAGENTA;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e i, logic [31:0] d);
      case (i)
        CFG_DEST_X:       dest_x = d[12:0];
        CFG_DEST_Y:       dest_y = d[12:0];
        CFG_DRAW_WIDTH:   draw_w = d[11:0];
        CFG_DRAW_HEIGHT:  draw_h = d[11:0];
        CFG_TEX_WIDTH:    tex_w = d[6:0];
        CFG_TEX_HEIGHT:   tex_h = d[6:0];
        CFG_SPRITE_DEPTH: sprite_z = d[23:0];
        default:          key = d;
      endcase
    endfunction

    function int texel_addr(int ox, int oy);
      int sx, sy, a;
      if (ox >= draw_w || oy >= draw_h) return -1;
      sx = ox * int'(tex_w) / int'(draw_w);
      sy = oy * int'(tex_h) / int'(draw_h);
      a = sy * int'(tex_w) + sx;
      return (a >= TEX_N) ? -1 : a;
    endfunction

    // Screen column that the depth test reads, or -1 when it is not read.
    function int depth_col(int ox, int oy);
      int a, x, y;
      a = texel_addr(ox, oy);
      if (a < 0) return -1;
      if (texels[a] == key) return -1;
      x = int'($signed(dest_x)) + ox;
      y = int'($signed(dest_y)) + oy;
      if (x <= 0 || y <= 0 || x >= SCR_W || y >= SCR_H) return -1;
      return x;
    endfunction

    function void note_input(op_e op, logic [11:0] idx, logic [31:0] val,
                             logic [11:0] ox, logic [11:0] oy);
      res_t r;
      int   a, x, y;
      r = '0;
      if (op == OP_TEXEL) begin
        if (idx < TEX_N) begin
          texels[idx] = val; tex_set[idx] = 1'b1;
        end
      end else if (op == OP_DEPTH) begin
        if (idx < SCR_W) begin
          col_z[idx] = val[23:0]; col_set[idx] = 1'b1;
        end
      end else if (op == OP_DRAW) begin
        x = depth_col(ox, oy);
        if (x >= 0 && sprite_z < col_z[x]) begin
          a = texel_addr(ox, oy);
          y = int'($signed(dest_y)) + int'(oy);
          r.we = 1'b1;
          r.addr = 20'(y * SCR_W + x);
          r.color = texels[a];
        end
      end
      pending.push_back(r);
    endfunction

    function void report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endfunction

    function void check_result(logic we, logic [19:0] addr, logic [31:0] color);
      res_t e;
      if (pending.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      e = pending.pop_front();
      if (we !== e.we) report($sformatf("write_enable %0b, expected %0b", we, e.we));
      if (addr !== e.addr)
        report($sformatf("screen_address %0h, expected %0h", addr, e.addr));
      if (color !== e.color)
        report($sformatf("pixel_color %0h, expected %0h", color, e.color));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  opcode_i = '0;
  logic [11:0] load_index_i = '0;
  logic [31:0] load_value_i = '0;
  logic [11:0] offset_x_i = '0;
  logic [11:0] offset_y_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        write_enable_o;
  logic [19:0] screen_address_o;
  logic [31:0] pixel_color_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  blit_scoreboard sb = new();
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  bit  hold_req  = 1'b0;
  int  cycles    = 0;

  scaled_sprite_blit_depth_test u_dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always begin
    int stall;
    if (!rst_ni) begin
      @(posedge clk_i);
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      stall = recv_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_result(write_enable_o, screen_address_o, pixel_color_o);
    end
  end

  task automatic send_item(op_e op, logic [11:0] idx, logic [31:0] val,
                           logic [11:0] ox, logic [11:0] oy);
    int gap;
    gap = send_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= op;
    load_index_i <= idx;
    load_value_i <= val;
    offset_x_i <= ox;
    offset_y_i <= oy;
    do @(posedge clk_i); while (full);
    sb.note_input(op, idx, val, ox, oy);
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e i, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= i;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(i, d);
  endtask

  task automatic write_all(int dx, int dy, int dw, int dh, int tw, int th,
                           logic [23:0] z, logic [31:0] k);
    settle();
    write_reg(CFG_DEST_X, 32'(dx));
    write_reg(CFG_DEST_Y, 32'(dy));
    write_reg(CFG_DRAW_WIDTH, 32'(dw));
    write_reg(CFG_DRAW_HEIGHT, 32'(dh));
    write_reg(CFG_TEX_WIDTH, 32'(tw));
    write_reg(CFG_TEX_HEIGHT, 32'(th));
    write_reg(CFG_SPRITE_DEPTH, {8'($urandom_range(0, 255)), z});
    write_reg(CFG_KEY_COLOR, k);
    cfg_valid_i <= 1'b0;
  endtask

  // Any state a draw will read is loaded first, so no unwritten entry is read.
  task automatic draw(int ox, int oy);
    int a, x;
    logic [31:0] c;
    logic [23:0] z;
    a = sb.texel_addr(ox, oy);
    if (a >= 0 && !sb.tex_set[a]) begin
      c = ($urandom_range(0, 4) == 0) ? sb.key : $urandom;
      send_item(OP_TEXEL, 12'(a), c, 12'($urandom), 12'($urandom));
    end
    x = sb.depth_col(ox, oy);
    if (x >= 0 && !sb.col_set[x]) begin
      z = sb.sprite_z + 24'($urandom_range(0, 6)) - 24'd3;
      if ($urandom_range(0, 3) == 0) z = 24'($urandom);
      send_item(OP_DEPTH, 12'(x), {8'($urandom), z}, 12'($urandom), 12'($urandom));
    end
    send_item(OP_DRAW, 12'($urandom), $urandom, 12'(ox), 12'(oy));
  endtask

  task automatic random_item();
    int sel, ox, oy;
    logic [23:0] z;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      send_item(OP_TEXEL, 12'($urandom), ($urandom_range(0, 3) == 0) ? sb.key : $urandom,
                12'($urandom), 12'($urandom));
    end else if (sel < 16) begin
      z = sb.sprite_z + 24'($urandom_range(0, 6)) - 24'd3;
      send_item(OP_DEPTH, 12'($urandom_range(0, 4095)), {8'($urandom), z},
                12'($urandom), 12'($urandom));
    end else if (sel < 19) begin
      send_item(OP_NOP, 12'($urandom), $urandom, 12'($urandom), 12'($urandom));
    end else if (sel < 26 || sb.draw_w == 0 || sb.draw_h == 0) begin
      draw($urandom_range(0, 4095), $urandom_range(0, 4095));
    end else begin
      ox = $urandom_range(0, sb.draw_w - 1);
      oy = $urandom_range(0, sb.draw_h - 1);
      draw(ox, oy);
    end
  endtask

  initial begin
    int dw, dh;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero draw size, loads at the ends of their ranges.
    draw(0, 0);
    draw(4095, 4095);
    send_item(OP_TEXEL, 12'd4095, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
    send_item(OP_TEXEL, 12'd0, 32'h0, 12'h0, 12'h0);
    send_item(OP_DEPTH, 12'd1023, 32'hFFFF_FFFF, 12'h0, 12'h0);
    send_item(OP_DEPTH, 12'd1024, 32'h1234_5678, 12'h0, 12'h0);
    send_item(OP_DEPTH, 12'd4095, 32'h0, 12'h0, 12'h0);
    send_item(OP_NOP, 12'hFFF, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);

    write_all(1, 1, 8, 8, 8, 8, 24'd100, MAGENTA);
    send_item(OP_TEXEL, 12'd0, MAGENTA, 12'h0, 12'h0);
    send_item(OP_DEPTH, 12'd2, 32'd100, 12'h0, 12'h0);
    send_item(OP_DEPTH, 12'd3, 32'd101, 12'h0, 12'h0);
    send_item(OP_TEXEL, 12'd1, 32'h0012_3456, 12'h0, 12'h0);
    draw(0, 0);
    draw(1, 0);
    draw(2, 0);
    draw(7, 7);
    draw(8, 0);
    write_all(-4096, 4095, 4095, 4095, 100, 100, 24'd0, 32'h0);
    draw(4094, 4094);
    draw(4095, 0);
    write_all(4095, -4096, 1, 1, 0, 0, 24'hFF_FFFF, 32'hFFFF_FFFF);
    draw(0, 0);
    write_all(0, 0, 64, 64, 64, 64, 24'd50, MAGENTA);
    draw(1, 1);
    draw(63, 63);

    for (int ph = 0; ph < 11; ph++) begin
      send_idle = (ph % 4) != 1;
      recv_idle = (ph % 4) != 2;
      if ($urandom_range(0, 4) == 0) begin
        dw = $urandom_range(1, 4095); dh = $urandom_range(1, 4095);
      end else begin
        dw = $urandom_range(1, 80); dh = $urandom_range(1, 80);
      end
      write_all($urandom_range(0, 1100) - 60, $urandom_range(0, 820) - 60, dw, dh,
                $urandom_range(1, 64), $urandom_range(1, 64), 24'($urandom),
                (ph % 3 == 0) ? MAGENTA : $urandom);
      if (ph == 3) hold_req = 1'b1;
      repeat (60) random_item();
    end

    settle();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
